// ===== hw/rtl/sacog_pkg.sv =====
// ----------------------------------------------------------------------------
// sacog_pkg
// Shared widths, register indexes and types for the sub-array chunk offset
// generator.
// ----------------------------------------------------------------------------
package sacog_pkg;

    // field widths
    localparam int OFFSET_W   = 48;
    localparam int EXT_W      = 17;
    localparam int START_W    = 16;
    localparam int STRIDE_W   = 2 * EXT_W;
    localparam int CFG_IDX_W  = 3;
    localparam int IN_TDATA_W = 8;
    localparam int OUT_TDATA_W = 72;

    // cycles of the geometry setup pass after reset or a register write
    localparam logic [2:0] SETUP_CYCLES = 3'd5;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ARRAY_EXT0  = 3'd0,
        REG_ARRAY_EXT1  = 3'd1,
        REG_REGION_ST0  = 3'd2,
        REG_REGION_ST1  = 3'd3,
        REG_REGION_ST2  = 3'd4,
        REG_REGION_EXT0 = 3'd5,
        REG_REGION_EXT1 = 3'd6,
        REG_REGION_EXT2 = 3'd7
    } cfg_reg_t;

    // geometry handed from the setup unit to the chunk stepper
    typedef struct packed {
        logic                busy;
        logic                load;
        logic [OFFSET_W-1:0] first_base;
        logic [OFFSET_W-1:0] plane_base;
        logic [OFFSET_W-1:0] offset;
        logic [STRIDE_W-1:0] plane_stride;
        logic [EXT_W-1:0]    row_stride;
        logic [EXT_W-1:0]    chunk_len;
        logic [EXT_W-1:0]    region_ext1;
        logic [EXT_W-1:0]    region_ext2;
    } sacog_geom_t;

endpackage

// ===== hw/rtl/sub_array_chunk_offset_generator.sv =====
// ----------------------------------------------------------------------------
// sub_array_chunk_offset_generator
// Streams the start offsets of the contiguous chunks of a rectangular
// sub-array of a column-major array of up to three dimensions.
// ----------------------------------------------------------------------------
// Usage:
//   Each transaction on the s_ channel requests one chunk; s_tdata bit 0 is
//   restart, which clears the dimension one/two odometer first. Each request
//   gives one transaction on the m_ channel: the chunk offset and length in
//   m_tdata, the final chunk of the region flagged by m_tlast. The odometer
//   wraps to the first chunk after the final one.
//   m_tvalid rises in the cycle after a request is taken. One request is taken
//   every cycle while no setup pass runs and m_tready does not stall, since the
//   next chunk only needs a counter step and a 48-bit add on the running offset.
//   The cfg_ channel writes the region and array geometry; cfg_ready is
//   always high. After reset and after every register write a setup pass
//   rebuilds the base offsets and strides through the multipliers;
//   s_tready stays low during it. Write registers only while idle.
//   Reset loads the register defaults (extents 1, starts 0) and clears the odometer.
//   When m_tready is low the result is held in the output register and
//   s_tready drops until it is taken.
// ----------------------------------------------------------------------------
module sub_array_chunk_offset_generator #(
    parameter int NUM_DIMS   = 3,
    parameter int INDEX_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // request stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sacog_pkg::IN_TDATA_W-1:0]  s_tdata,   // [0] restart
    // chunk stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [sacog_pkg::OUT_TDATA_W-1:0] m_tdata,   // [47:0] chunk_offset,
                                                         // [64:48] chunk_length
    output logic                               m_tlast,   // last_chunk
    // register writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sacog_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sacog_pkg::EXT_W-1:0]       cfg_data
);
    import sacog_pkg::*;

    sacog_geom_t               geom;
    logic [INDEX_BITS-1:0]     index_dim1, index_dim2;
    logic [OFFSET_W-1:0]       chunk_offset;
    logic [EXT_W-1:0]          chunk_length;

    // configuration and setup pass
    sacog_setup #(
        .NUM_DIMS   (NUM_DIMS),
        .INDEX_BITS (INDEX_BITS)
    ) u_setup (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .index_dim1 (index_dim1),
        .index_dim2 (index_dim2),
        .geom       (geom)
    );

    // odometer and result register
    sacog_stepper #(
        .INDEX_BITS (INDEX_BITS)
    ) u_stepper (
        .clk        (clk),
        .rst_n      (rst_n),
        .geom       (geom),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .restart    (s_tdata[0]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_offset (chunk_offset),
        .out_length (chunk_length),
        .out_last   (m_tlast),
        .index_dim1 (index_dim1),
        .index_dim2 (index_dim2)
    );

    // pack the chunk fields, zero filled to whole bytes
    assign m_tdata = {{(OUT_TDATA_W - OFFSET_W - EXT_W){1'b0}}, chunk_length, chunk_offset};

endmodule

// ===== hw/rtl/sacog_setup.sv =====
// ----------------------------------------------------------------------------
// sacog_setup
// Configuration registers and the pipelined setup pass that turns them,
// together with the current odometer, into base offsets and strides.
// ----------------------------------------------------------------------------
module sacog_setup #(
    parameter int NUM_DIMS   = 3,
    parameter int INDEX_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sacog_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sacog_pkg::EXT_W-1:0]     cfg_data,
    input  logic [INDEX_BITS-1:0]           index_dim1,
    input  logic [INDEX_BITS-1:0]           index_dim2,
    output sacog_pkg::sacog_geom_t          geom
);
    import sacog_pkg::*;

    localparam int IW  = INDEX_BITS;
    localparam int SW  = ((IW > START_W) ? IW : START_W) + 1;

    logic [EXT_W-1:0]   array_ext0_reg, array_ext1_reg;
    logic [START_W-1:0] region_st0_reg, region_st1_reg, region_st2_reg;
    logic [EXT_W-1:0]   region_ext0_reg, region_ext1_reg, region_ext2_reg;
    logic [2:0]         setup_cnt_reg, setup_cnt_next;

    logic [START_W-1:0] st1_eff, st2_eff;
    logic [EXT_W-1:0]   ext1_eff, ext2_eff;

    // stage 1
    logic [STRIDE_W-1:0]       stride_reg;
    logic [START_W+EXT_W-1:0]  s1a0_reg;
    logic [IW+EXT_W-1:0]       i1a0_reg;
    logic [SW-1:0]             s2i2_reg;
    logic [START_W-1:0]        s2_reg;
    // stage 2
    logic [SW+EXT_W-1:0]       pl_lo_reg, pl_hi_reg;
    logic [START_W+EXT_W-1:0]  fp_lo_reg, fp_hi_reg;
    // stage 3
    logic [OFFSET_W-1:0]       plane_base_reg, first_base_reg;
    // stage 4
    logic [OFFSET_W-1:0]       offset_reg;

    assign cfg_ready = 1'b1;

    // unused dimensions take start 0 and extent 1
    assign st1_eff  = (NUM_DIMS >= 2) ? region_st1_reg  : '0;
    assign st2_eff  = (NUM_DIMS >= 3) ? region_st2_reg  : '0;
    assign ext1_eff = (NUM_DIMS >= 2) ? region_ext1_reg : EXT_W'(1);
    assign ext2_eff = (NUM_DIMS >= 3) ? region_ext2_reg : EXT_W'(1);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            array_ext0_reg  <= EXT_W'(1);
            array_ext1_reg  <= EXT_W'(1);
            region_st0_reg  <= '0;
            region_st1_reg  <= '0;
            region_st2_reg  <= '0;
            region_ext0_reg <= EXT_W'(1);
            region_ext1_reg <= EXT_W'(1);
            region_ext2_reg <= EXT_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ARRAY_EXT0:  array_ext0_reg  <= cfg_data;
                REG_ARRAY_EXT1:  array_ext1_reg  <= cfg_data;
                REG_REGION_ST0:  region_st0_reg  <= cfg_data[START_W-1:0];
                REG_REGION_ST1:  region_st1_reg  <= cfg_data[START_W-1:0];
                REG_REGION_ST2:  region_st2_reg  <= cfg_data[START_W-1:0];
                REG_REGION_EXT0: region_ext0_reg <= cfg_data;
                REG_REGION_EXT1: region_ext1_reg <= cfg_data;
                REG_REGION_EXT2: region_ext2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // setup pass counter, restarted by every write
    always_comb
    begin
        if (cfg_valid && cfg_ready)
            setup_cnt_next = SETUP_CYCLES;
        else if (setup_cnt_reg != 3'd0)
            setup_cnt_next = setup_cnt_reg - 3'd1;
        else
            setup_cnt_next = setup_cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            setup_cnt_reg <= SETUP_CYCLES;
        else
            setup_cnt_reg <= setup_cnt_next;
    end

    // stage 1: strides and single products
    always_ff @(posedge clk)
    begin
        stride_reg <= STRIDE_W'(array_ext0_reg) * STRIDE_W'(array_ext1_reg);
        s1a0_reg   <= (START_W+EXT_W)'(st1_eff) * (START_W+EXT_W)'(array_ext0_reg);
        i1a0_reg   <= (IW+EXT_W)'(index_dim1) * (IW+EXT_W)'(array_ext0_reg);
        s2i2_reg   <= SW'(st2_eff) + SW'(index_dim2);
        s2_reg     <= st2_eff;
    end

    // stage 2: plane products split into two halves of the plane stride
    always_ff @(posedge clk)
    begin
        pl_lo_reg <= (SW+EXT_W)'(s2i2_reg) * (SW+EXT_W)'(stride_reg[EXT_W-1:0]);
        pl_hi_reg <= (SW+EXT_W)'(s2i2_reg) * (SW+EXT_W)'(stride_reg[STRIDE_W-1:EXT_W]);
        fp_lo_reg <= (START_W+EXT_W)'(s2_reg) * (START_W+EXT_W)'(stride_reg[EXT_W-1:0]);
        fp_hi_reg <= (START_W+EXT_W)'(s2_reg)
                     * (START_W+EXT_W)'(stride_reg[STRIDE_W-1:EXT_W]);
    end

    // stage 3: plane bases, modulo the offset width
    always_ff @(posedge clk)
    begin
        plane_base_reg <= OFFSET_W'(region_st0_reg) + OFFSET_W'(s1a0_reg)
                          + OFFSET_W'(pl_lo_reg) + (OFFSET_W'(pl_hi_reg) << EXT_W);
        first_base_reg <= OFFSET_W'(region_st0_reg) + OFFSET_W'(s1a0_reg)
                          + OFFSET_W'(fp_lo_reg) + (OFFSET_W'(fp_hi_reg) << EXT_W);
    end

    // stage 4: offset of the current chunk
    always_ff @(posedge clk)
    begin
        offset_reg <= plane_base_reg + OFFSET_W'(i1a0_reg);
    end

    // geometry bundle
    always_comb
    begin
        geom.busy         = (setup_cnt_reg != 3'd0);
        geom.load         = (setup_cnt_reg == 3'd1);
        geom.first_base   = first_base_reg;
        geom.plane_base   = plane_base_reg;
        geom.offset       = offset_reg;
        geom.plane_stride = stride_reg;
        geom.row_stride   = array_ext0_reg;
        geom.chunk_len    = region_ext0_reg;
        geom.region_ext1  = ext1_eff;
        geom.region_ext2  = ext2_eff;
    end

endmodule

// ===== hw/rtl/sacog_stepper.sv =====
// ----------------------------------------------------------------------------
// sacog_stepper
// Odometer over dimensions one and two with incremental chunk offsets and
// the result register of the output stream.
// ----------------------------------------------------------------------------
module sacog_stepper #(
    parameter int INDEX_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sacog_pkg::sacog_geom_t          geom,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            restart,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [sacog_pkg::OFFSET_W-1:0] out_offset,
    output logic [sacog_pkg::EXT_W-1:0]    out_length,
    output logic                            out_last,
    output logic [INDEX_BITS-1:0]          index_dim1,
    output logic [INDEX_BITS-1:0]          index_dim2
);
    import sacog_pkg::*;

    localparam int IW = INDEX_BITS;
    localparam int CW = ((IW + 1) > EXT_W) ? (IW + 1) : EXT_W;

    logic [IW-1:0]       i1_reg, i1_next, i2_reg, i2_next;
    logic [OFFSET_W-1:0] off_reg, off_next, pbase_reg, pbase_next;
    logic                vld_reg;
    logic [OFFSET_W-1:0] res_off_reg;
    logic [EXT_W-1:0]    res_len_reg;
    logic                res_last_reg;

    logic                accept;
    logic [IW-1:0]       i1_eff, i2_eff, i1_inc, i2_inc;
    logic [OFFSET_W-1:0] off_eff, pbase_eff;
    logic                last1, last2;

    assign in_ready = !geom.busy && (!vld_reg || out_ready);
    assign accept   = in_valid && in_ready;

    // restart starts over from the first chunk
    assign i1_eff    = restart ? '0 : i1_reg;
    assign i2_eff    = restart ? '0 : i2_reg;
    assign off_eff   = restart ? geom.first_base : off_reg;
    assign pbase_eff = restart ? geom.first_base : pbase_reg;

    assign i1_inc = i1_eff + IW'(1);
    assign i2_inc = i2_eff + IW'(1);

    // a digit is last once its index plus one reaches the extent
    assign last1 = (CW'(i1_eff) + CW'(1)) >= CW'(geom.region_ext1);
    assign last2 = (CW'(i2_eff) + CW'(1)) >= CW'(geom.region_ext2);

    // odometer advance and next offsets
    always_comb
    begin
        i1_next    = i1_inc;
        i2_next    = i2_eff;
        pbase_next = pbase_eff;
        off_next   = off_eff + OFFSET_W'(geom.row_stride);
        if (last1)
        begin
            i1_next = '0;
            if (last2 || (i2_inc == '0))
            begin
                i2_next    = last2 ? '0 : i2_inc;
                pbase_next = geom.first_base;
            end
            else
            begin
                i2_next    = i2_inc;
                pbase_next = pbase_eff + OFFSET_W'(geom.plane_stride);
            end
            off_next = pbase_next;
        end
        else if (i1_inc == '0)
        begin
            // index wrapped by its width: back to the plane start
            off_next = pbase_eff;
        end
    end

    // odometer indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i1_reg <= '0;
            i2_reg <= '0;
        end
        else if (accept)
        begin
            i1_reg <= i1_next;
            i2_reg <= i2_next;
        end
    end

    // running offsets, reloaded by the setup pass
    always_ff @(posedge clk)
    begin
        if (geom.load)
        begin
            off_reg   <= geom.offset;
            pbase_reg <= geom.plane_base;
        end
        else if (accept)
        begin
            off_reg   <= off_next;
            pbase_reg <= pbase_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (accept)
            vld_reg <= 1'b1;
        else if (out_ready)
            vld_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_off_reg  <= off_eff;
            res_len_reg  <= geom.chunk_len;
            res_last_reg <= last1 && last2;
        end
    end

    assign out_valid  = vld_reg;
    assign out_offset = res_off_reg;
    assign out_length = res_len_reg;
    assign out_last   = res_last_reg;
    assign index_dim1 = i1_reg;
    assign index_dim2 = i2_reg;

endmodule
